[rtl/lmat_pkg.sv]
// ============================================================================
// Light moving-average trigger package
// Shared constants and the command/status types between controller and
// datapath.
// ============================================================================
`default_nettype none

package lmat_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LEVEL_W       = 10;
    localparam int PERCENT_SCALE = 100;
    localparam int PROD_W        = SAMPLE_W + LEVEL_W;

    localparam logic [LEVEL_W-1:0]  LEVEL_RESET = LEVEL_W'(110);
    localparam logic [SAMPLE_W-1:0] AVG_MAX     = {SAMPLE_W{1'b1}};

    typedef struct packed {
        logic accept;
        logic fill_step;
        logic calc_prod;
        logic calc_num;
        logic div_start;
        logic update_fill;
        logic update_steady;
        logic mul;
        logic cmp;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic filling;
        logic fill_last;
        logic div_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

[rtl/light_moving_average_trigger_core.sv]
// ============================================================================
// Light moving-average trigger core
// Running average of light samples with a ratio-of-averages trigger.
// ============================================================================
// Usage:
//   Input channel in_valid/in_ready carries one light_sample per request.
//   Output channel out_valid/out_ready returns one result per request:
//   average_out, trigger, warming_up and init_error.
//   cfg_wr_en/cfg_wr_data write level_percent (reset value 110); write it
//   only while no request is in flight.
//   One request is processed at a time: the next is accepted only after the
//   last result is loaded. A sample that goes into the initial window takes
//   a fill step and the output load. The sample that closes the window adds
//   the reciprocal divide by WINDOW_SIZE and the average update. Every later
//   one runs window product, numerator, divide, average update, percent
//   products, compare and output load, which waits until the output is free.
//   The result sits in an output register, so the next request is accepted
//   and processed while out_ready is low; processing stops only when a
//   second result is ready and the register is still full.
//   Reset clears the window, average, error flag and both channels; the
//   sample ring holds no data until the first WINDOW_SIZE samples arrive.
// ============================================================================
`default_nettype none

module light_moving_average_trigger_core #(
    parameter int WINDOW_SIZE = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lmat_pkg::LEVEL_W-1:0]  cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lmat_pkg::SAMPLE_W-1:0] light_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [lmat_pkg::SAMPLE_W-1:0] average_out,
    output logic                               trigger,
    output logic                               warming_up,
    output logic                               init_error
);

    lmat_pkg::dp_cmd_t cmd;
    lmat_pkg::dp_sts_t sts;

    lmat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lmat_datapath #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .light_sample(light_sample),
        .average_out (average_out),
        .trigger     (trigger),
        .warming_up  (warming_up),
        .init_error  (init_error)
    );

endmodule

`default_nettype wire

[rtl/lmat_ram.sv]
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data, no reset on storage.
// ============================================================================
`default_nettype none

module lmat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/lmat_div.sv]
// ============================================================================
// Constant divider
// Division by a fixed divisor through reciprocal multiplication: the product
// is registered, then its shifted upper bits are registered as the quotient.
// ============================================================================
`default_nettype none

module lmat_div #(
    parameter int DW      = 20,
    parameter int DIVISOR = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    output logic               busy,
    output logic      [DW-1:0] quotient
);

    localparam int LW    = $clog2(DIVISOR);
    localparam int SHIFT = DW + LW;
    localparam int MW    = DW + 1;
    localparam int PRW   = DW + MW;

    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PRW-1:0] prod_reg;
    logic [DW-1:0]  quo_reg;
    logic           busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PRW'(dividend) * PRW'(RECIP);
        end
        if (busy_reg)
        begin
            quo_reg <= DW'(prod_reg[PRW-1:SHIFT]);
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/lmat_datapath.sv]
// ============================================================================
// Light moving-average trigger datapath
// Sample ring, fill sum, running average, divider and ratio compare.
// ============================================================================
`default_nettype none

module lmat_datapath #(
    parameter int WINDOW_SIZE = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lmat_pkg::dp_cmd_t                cmd,
    output lmat_pkg::dp_sts_t                     sts,
    input  wire logic                             cfg_wr_en,
    input  wire logic [lmat_pkg::LEVEL_W-1:0]     cfg_wr_data,
    input  wire logic [lmat_pkg::SAMPLE_W-1:0]    light_sample,
    output logic      [lmat_pkg::SAMPLE_W-1:0]    average_out,
    output logic                                  trigger,
    output logic                                  warming_up,
    output logic                                  init_error
);

    localparam int SW     = lmat_pkg::SAMPLE_W;
    localparam int AW     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW     = $clog2(WINDOW_SIZE + 1);
    localparam int DVW    = $clog2(WINDOW_SIZE + 1);
    localparam int DW     = SW + DVW;
    localparam int PW     = lmat_pkg::PROD_W;

    logic [lmat_pkg::LEVEL_W-1:0] level_reg;
    logic [SW-1:0] sample_reg;
    logic [SW-1:0] avg_reg;
    logic [SW-1:0] old_reg;
    logic [CW-1:0] fill_count_reg;
    logic [DW-1:0] fill_sum_reg;
    logic [AW-1:0] pos_reg;
    logic          err_reg;
    logic          warm_reg;
    logic          trig_reg;
    logic [DW-1:0] prod_reg;
    logic [DW-1:0] num_reg;
    logic          neg_reg;
    logic [PW-1:0] p_new_reg;
    logic [PW-1:0] p_old_reg;

    logic [SW-1:0] average_out_reg;
    logic          trigger_reg;
    logic          warming_up_reg;
    logic          init_error_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_rdata;
    logic [DW:0]   steady_num;
    logic [DW-1:0] fill_total;
    logic          div_busy;
    logic [DW-1:0] quotient;
    logic [SW-1:0] next_avg;

    lmat_ram #(
        .WIDTH(SW),
        .DEPTH(WINDOW_SIZE)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(sample_reg),
        .re   (cmd.accept),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    lmat_div #(
        .DW     (DW),
        .DIVISOR(WINDOW_SIZE)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(num_reg),
        .busy    (div_busy),
        .quotient(quotient)
    );

    assign ram_we     = cmd.fill_step || cmd.calc_num;
    assign ram_waddr  = cmd.fill_step ? fill_count_reg[AW-1:0] : pos_reg;
    assign fill_total = fill_sum_reg + DW'(sample_reg);
    assign steady_num = (DW+1)'(prod_reg) + (DW+1)'(sample_reg) - (DW+1)'(ram_rdata);

    always_comb
    begin
        if (neg_reg)
        begin
            next_avg = '0;
        end
        else if (|quotient[DW-1:SW])
        begin
            next_avg = lmat_pkg::AVG_MAX;
        end
        else
        begin
            next_avg = quotient[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= lmat_pkg::LEVEL_RESET;
            avg_reg        <= '0;
            fill_count_reg <= '0;
            fill_sum_reg   <= '0;
            pos_reg        <= '0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                level_reg <= cfg_wr_data;
            end
            if (cmd.fill_step)
            begin
                fill_sum_reg   <= fill_total;
                fill_count_reg <= fill_count_reg + CW'(1);
            end
            if (cmd.calc_num)
            begin
                if (pos_reg == AW'(WINDOW_SIZE - 1))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + AW'(1);
                end
            end
            if (cmd.update_fill)
            begin
                avg_reg <= next_avg;
                if (next_avg == '0)
                begin
                    err_reg <= 1'b1;
                end
            end
            if (cmd.update_steady)
            begin
                avg_reg <= next_avg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= light_sample;
            warm_reg   <= sts.filling;
            trig_reg   <= 1'b0;
        end
        if (cmd.calc_prod)
        begin
            prod_reg <= DW'(avg_reg) * DW'(WINDOW_SIZE);
        end
        if (cmd.fill_step)
        begin
            num_reg <= fill_total;
            neg_reg <= 1'b0;
        end
        if (cmd.calc_num)
        begin
            num_reg <= steady_num[DW-1:0];
            neg_reg <= steady_num[DW];
        end
        if (cmd.update_steady)
        begin
            old_reg <= avg_reg;
        end
        if (cmd.mul)
        begin
            p_new_reg <= PW'(avg_reg) * PW'(lmat_pkg::PERCENT_SCALE);
            p_old_reg <= PW'(level_reg) * PW'(old_reg);
        end
        if (cmd.cmp)
        begin
            trig_reg <= !err_reg && (old_reg != '0) && (p_new_reg >= p_old_reg);
        end
        if (cmd.out_load)
        begin
            average_out_reg <= avg_reg;
            trigger_reg     <= trig_reg;
            warming_up_reg  <= warm_reg;
            init_error_reg  <= err_reg;
        end
    end

    assign sts.filling   = (fill_count_reg != CW'(WINDOW_SIZE));
    assign sts.fill_last = (fill_count_reg == CW'(WINDOW_SIZE - 1));
    assign sts.div_busy  = div_busy;

    assign average_out = average_out_reg;
    assign trigger     = trigger_reg;
    assign warming_up  = warming_up_reg;
    assign init_error  = init_error_reg;

endmodule

`default_nettype wire

[rtl/lmat_ctrl.sv]
// ============================================================================
// Light moving-average trigger controller
// Sequences one request through fill or steady-state update and the output
// register.
// ============================================================================
`default_nettype none

module lmat_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lmat_pkg::dp_cmd_t      cmd,
    input  wire lmat_pkg::dp_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_CALC,
        S_DSTART,
        S_DWAIT,
        S_UPDATE,
        S_MUL,
        S_CMP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   fill_mode_reg, fill_mode_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        fill_mode_next = fill_mode_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.filling ? S_FILL : S_READ;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    fill_mode_next = 1'b1;
                    state_next     = S_DSTART;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc_num   = 1'b1;
                fill_mode_next = 1'b0;
                state_next     = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (fill_mode_reg)
                begin
                    cmd.update_fill = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.update_steady = 1'b1;
                    state_next        = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_mode_reg <= fill_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/lmat_checker.sv]
// ============================================================================
// Light moving-average trigger checker
// Port-level properties of the core, attached by bind.
// ============================================================================
`default_nettype none

module lmat_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [lmat_pkg::SAMPLE_W-1:0] average_out,
    input wire logic                          trigger,
    input wire logic                          warming_up,
    input wire logic                          init_error
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_out)
            && $stable(trigger) && $stable(warming_up) && $stable(init_error))
        else $error("stalled result changed");

    a_no_trig_warm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger |-> !warming_up)
        else $error("trigger during initial window");

    a_no_trig_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger |-> !init_error)
        else $error("trigger with init error set");

endmodule

bind light_moving_average_trigger_core lmat_checker u_lmat_checker (.*);

`default_nettype wire
